### src/akrt_pkg.sv
package akrt_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int KEY_BITS     = 4;
  localparam int MM_BITS      = 6;
  localparam int MM_FULL      = 40;
  localparam int CFG_IDX_BITS = 2;
  // power of two, so the queue pointers wrap on their own
  localparam int QUEUE_DEPTH  = 2;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = '1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ACTUATION  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RAPID      = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SENSITIVITY = 2'd3;

  localparam logic [MM_BITS-1:0] ACTUATION_RESET   = 6'd20;
  localparam logic [MM_BITS-1:0] RELEASE_RESET     = 6'd15;
  localparam logic [MM_BITS-1:0] SENSITIVITY_RESET = 6'd3;

  typedef enum logic [0:0] {
    OP_SAMPLE    = 1'b0,
    OP_CALIBRATE = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 operation;
    logic [KEY_BITS-1:0] key;
    sample_t             reading;
    sample_t             bound_low;
    sample_t             bound_high;
  } in_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key_out;
    logic                pressed;
    sample_t             average;
  } out_item_t;

  typedef struct packed {
    logic [MM_BITS-1:0] actuation_point;
    logic [MM_BITS-1:0] release_point;
    logic               rapid_mode;
    logic [MM_BITS-1:0] sensitivity;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_RING,
    S_SCALE,
    S_DONE
  } back_state_t;

endpackage

### src/akrt_ram.sv
module akrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/akrt_front.sv
module akrt_front import akrt_pkg::*; #(
  parameter int KEYS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     cmd_valid,
  output in_item_t cmd,
  input  logic     cmd_ready
);

  logic key_ok;
  logic in_take;
  logic cmd_valid_next;

  assign key_ok   = int'(in_data.key) < KEYS;
  assign in_stall = cmd_valid && !cmd_ready;
  assign in_take  = in_valid && !in_stall;

  // drop keys outside the array here; they never reach the back end
  always_comb begin
    cmd_valid_next = cmd_valid && !cmd_ready;
    if (in_take) begin
      cmd_valid_next = key_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= cmd_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd <= in_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
    else $error("front: command changed while waiting for the queue");

endmodule

### src/akrt_queue.sv
module akrt_queue import akrt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  in_item_t push_data,
  output logic     pop_valid,
  input  logic     pop,
  output in_item_t pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  in_item_t         slot [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != (PTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue: fill level beyond depth");

endmodule

### src/akrt_back.sv
module akrt_back import akrt_pkg::*; #(
  parameter int KEYS    = 16,
  parameter int AVG_LEN = 15
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      head_valid,
  output logic      pop,
  input  in_item_t  head,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int KEY_AW     = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int POS_W      = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;
  localparam int RING_DEPTH = KEYS * AVG_LEN;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W      = SAMPLE_BITS + $clog2(AVG_LEN);
  // floor(x / AVG_LEN) = (x * AVG_MUL) >> AVG_SH, exact for every x below 2**SUM_W
  localparam int AVG_SH     = SUM_W + $clog2(AVG_LEN);
  localparam int AVG_MUL_W  = SUM_W + 1;
  localparam logic [AVG_MUL_W-1:0] AVG_MUL =
    AVG_MUL_W'((64'd1 << AVG_SH) / AVG_LEN + 1);
  // distance scaling: mm * (hi - lo) / MM_FULL, truncated toward zero
  localparam int DIFF_W     = SAMPLE_BITS + 1;
  localparam int PROD_W     = DIFF_W + MM_BITS + 1;
  localparam int MAG_W      = SAMPLE_BITS + MM_BITS;
  localparam int MM_SH      = MAG_W + $clog2(MM_FULL);
  localparam int MM_MUL_W   = MAG_W + 1;
  localparam logic [MM_MUL_W-1:0] MM_MUL =
    MM_MUL_W'((64'd1 << MM_SH) / MM_FULL + 1);
  localparam int Q_W        = MAG_W + MM_MUL_W - MM_SH;
  localparam int CL_W       = Q_W + 2;

  typedef struct packed {
    sample_t low;
    sample_t high;
  } cal_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [POS_W-1:0] pos;
    logic             filled;
    sample_t          ext;
    logic             pressed;
  } key_state_t;

  function automatic logic signed [Q_W:0] div_mm(input logic signed [PROD_W-1:0] p);
    logic [MAG_W-1:0]          mag;
    logic [MAG_W+MM_MUL_W-1:0] wide;
    logic [Q_W-1:0]            q;
    mag  = p[PROD_W-1] ? MAG_W'(-p) : MAG_W'(p);
    wide = (MAG_W + MM_MUL_W)'(mag) * (MAG_W + MM_MUL_W)'(MM_MUL);
    q    = wide[MM_SH +: Q_W];
    return p[PROD_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  function automatic sample_t sat_sample(input logic signed [CL_W-1:0] v);
    sample_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(CL_W'(SAMPLE_MAX))) begin
      r = SAMPLE_MAX;
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  back_state_t state, state_next;

  logic [KEY_AW-1:0]  head_key;
  logic [KEY_AW-1:0]  cur_key;
  sample_t            cur_reading;
  logic [KEYS-1:0]    st_valid;
  logic [KEYS-1:0]    cal_valid;
  logic               st_ok;
  logic               cal_ok;

  key_state_t         st_rdata, st_wdata, ks, ks_adv, ks_q;
  logic               st_we;
  cal_t               cal_rdata, cal_wdata;
  logic               cal_we;
  sample_t            ring_rdata;
  logic               ring_we;
  logic [RING_AW-1:0] ring_addr, ring_addr_q;

  logic [POS_W-1:0]   pos_next;
  sample_t            lo, hi, lo_q;
  logic signed [DIFF_W-1:0] diff_q;

  sample_t            old_sample;
  logic [SUM_W-1:0]   sum_new, sum_new_q;
  logic [MM_BITS-1:0] mm_b;
  logic signed [PROD_W-1:0] prod_a, prod_b, prod_a_q, prod_b_q;

  logic [SUM_W+AVG_MUL_W-1:0] avg_prod;
  logic [SAMPLE_BITS:0]       avg_quot;
  logic signed [CL_W-1:0]     lo_b;
  sample_t            act_val, thr_val;
  sample_t            avg_q, act_q, thr_q;

  sample_t            rel_lim, up_lim, ext_new;
  logic               now;
  logic               out_load;

  assign head_key = KEY_AW'(head.key);

  // control
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    cal_we     = 1'b0;
    ring_we    = 1'b0;
    st_we      = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          if (head.operation == OP_CALIBRATE) begin
            cal_we = 1'b1;
          end else begin
            state_next = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        state_next = S_RING;
      end
      S_RING: begin
        ring_we    = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold the finished key until the output register is free
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          st_we      = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // fetch: unwritten keys read as their reset values
  always_comb begin
    ks       = st_ok ? st_rdata : '0;
    lo       = cal_ok ? cal_rdata.low : '0;
    hi       = cal_ok ? cal_rdata.high : SAMPLE_MAX;
    pos_next = (ks.pos == POS_W'(AVG_LEN - 1)) ? '0 : ks.pos + 1'b1;
    ks_adv     = ks;
    ks_adv.pos = pos_next;
    ring_addr  = RING_AW'(int'(cur_key) * AVG_LEN + int'(pos_next));
  end

  // ring update: the slot about to be overwritten holds zero until the ring has wrapped once
  always_comb begin
    old_sample = ks_q.filled ? ring_rdata : '0;
    sum_new    = ks_q.sum - SUM_W'(old_sample) + SUM_W'(cur_reading);
    mm_b       = cfg.rapid_mode ? cfg.sensitivity : cfg.release_point;
    prod_a     = PROD_W'($signed({1'b0, cfg.actuation_point})) * PROD_W'(diff_q);
    prod_b     = PROD_W'($signed({1'b0, mm_b})) * PROD_W'(diff_q);
  end

  // scale: mean and thresholds
  always_comb begin
    avg_prod = (SUM_W + AVG_MUL_W)'(sum_new_q) * (SUM_W + AVG_MUL_W)'(AVG_MUL);
    avg_quot = avg_prod[AVG_SH +: SAMPLE_BITS + 1];
    lo_b     = cfg.rapid_mode ? '0 : $signed(CL_W'(lo_q));
    act_val  = sat_sample(CL_W'(div_mm(prod_a_q)) + $signed(CL_W'(lo_q)));
    thr_val  = sat_sample(CL_W'(div_mm(prod_b_q)) + lo_b);
  end

  // decide: thr_q is the sensitivity in rapid mode, the release point otherwise
  always_comb begin
    rel_lim = sat_sample($signed(CL_W'(ks_q.ext)) - $signed(CL_W'(thr_q)));
    up_lim  = sat_sample($signed(CL_W'(ks_q.ext)) + $signed(CL_W'(thr_q)));
    now     = ks_q.pressed;
    ext_new = ks_q.ext;
    if (cfg.rapid_mode) begin
      if (ks_q.pressed) begin
        if (avg_q < rel_lim) begin
          ext_new = avg_q;
          now     = 1'b0;
        end else begin
          now = 1'b1;
          if (avg_q > ks_q.ext) begin
            ext_new = avg_q;
          end
        end
      end else begin
        if (avg_q > up_lim && avg_q > act_q) begin
          ext_new = avg_q;
          now     = 1'b1;
        end else begin
          now = 1'b0;
          if (avg_q < ks_q.ext) begin
            ext_new = avg_q;
          end
        end
      end
    end else begin
      now = ks_q.pressed ? (avg_q > thr_q) : (avg_q > act_q);
    end
    st_wdata.sum     = sum_new_q;
    st_wdata.pos     = ks_q.pos;
    st_wdata.filled  = ks_q.filled || (ks_q.pos == '0);
    st_wdata.ext     = ext_new;
    st_wdata.pressed = now;
    cal_wdata.low    = head.bound_low;
    cal_wdata.high   = head.bound_high;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      st_valid  <= '0;
      cal_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cal_we) begin
        cal_valid[head_key] <= 1'b1;
      end
      if (st_we) begin
        st_valid[cur_key] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur_key     <= head_key;
        cur_reading <= head.reading;
        st_ok       <= st_valid[head_key];
        cal_ok      <= cal_valid[head_key];
      end
      S_FETCH: begin
        ks_q        <= ks_adv;
        lo_q        <= lo;
        diff_q      <= $signed({1'b0, hi}) - $signed({1'b0, lo});
        ring_addr_q <= ring_addr;
      end
      S_RING: begin
        sum_new_q <= sum_new;
        prod_a_q  <= prod_a;
        prod_b_q  <= prod_b;
      end
      S_SCALE: begin
        avg_q <= avg_quot[SAMPLE_BITS-1:0];
        act_q <= act_val;
        thr_q <= thr_val;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_data.key_out <= KEY_BITS'(cur_key);
      out_data.pressed <= now;
      out_data.average <= avg_q;
    end
  end

  akrt_ram #(
    .WIDTH ($bits(key_state_t)),
    .DEPTH (KEYS)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (cur_key),
    .wdata (st_wdata),
    .raddr (head_key),
    .rdata (st_rdata)
  );

  akrt_ram #(
    .WIDTH ($bits(cal_t)),
    .DEPTH (KEYS)
  ) u_cal_ram (
    .clk   (clk),
    .we    (cal_we),
    .waddr (head_key),
    .wdata (cal_wdata),
    .raddr (head_key),
    .rdata (cal_rdata)
  );

  akrt_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_addr_q),
    .wdata (cur_reading),
    .raddr (ring_addr),
    .rdata (ring_rdata)
  );

  assert property (@(posedge clk) disable iff (rst)
    state == S_FETCH |-> $past(state) == S_IDLE)
    else $error("back: fetch entered without a popped sample");

  assert property (@(posedge clk) disable iff (rst)
    state == S_SCALE |-> !avg_quot[SAMPLE_BITS])
    else $error("back: mean exceeds sample range");

  assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && state == S_IDLE)
    else $error("back: result load did not complete the sample");

endmodule

### src/analog_key_rapid_trigger_top.sv
// Channel  Handshake               Payload      Notes
// in       in_valid / in_stall     in_item_t    sample or calibration write per transfer
// out      out_valid / out_stall   out_item_t   one result per in-range sample
// cfg      cfg_write               cfg_data     register picked by cfg_index, no read-back
//
// In the back end a sample goes through key state and calibration RAM read, ring RAM
// read and sum update, scaling multiplies, then compare and write-back.
// Calibrations are written in the idle state; out-of-range keys are dropped in the front end.
// A two-entry queue between front and back keeps accepting while a result waits on out_stall.
// Reset is synchronous; per-key valid bits and a ring fill flag stand in for cleared RAMs,
// so there is no clearing pass after reset.
module analog_key_rapid_trigger_top import akrt_pkg::*; #(
  parameter int KEYS    = 16,
  parameter int AVG_LEN = 15
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_item_t                in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_item_t               out_data,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [MM_BITS-1:0]      cfg_data
);

  cfg_t     cfg;
  logic     cmd_valid;
  logic     cmd_ready;
  in_item_t cmd;
  logic     head_valid;
  logic     pop;
  in_item_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.actuation_point <= ACTUATION_RESET;
      cfg.release_point   <= RELEASE_RESET;
      cfg.rapid_mode      <= 1'b0;
      cfg.sensitivity     <= SENSITIVITY_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ACTUATION:   cfg.actuation_point <= cfg_data;
        CFG_RELEASE:     cfg.release_point   <= cfg_data;
        CFG_RAPID:       cfg.rapid_mode      <= cfg_data[0];
        CFG_SENSITIVITY: cfg.sensitivity     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  akrt_front #(
    .KEYS (KEYS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  akrt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_valid),
    .push_ready (cmd_ready),
    .push_data  (cmd),
    .pop_valid  (head_valid),
    .pop        (pop),
    .pop_data   (head)
  );

  akrt_back #(
    .KEYS    (KEYS),
    .AVG_LEN (AVG_LEN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .pop        (pop),
    .head       (head),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench import akrt_pkg::*;;

  localparam int KEY_COUNT   = 16;
  localparam int RING_LEN    = 15;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 110;
  localparam int SETTLE      = 20;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  in_item_t                in_data = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  out_item_t               out_data;
  logic                    cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_ACTUATION;
  logic [MM_BITS-1:0]      cfg_data = '0;

  analog_key_rapid_trigger_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // key state as the block should hold it
  sample_t            ring_store [KEY_COUNT][RING_LEN];
  int                 ring_slot [KEY_COUNT];
  sample_t            extreme [KEY_COUNT];
  bit                 key_down [KEY_COUNT];
  sample_t            cal_lo [KEY_COUNT];
  sample_t            cal_hi [KEY_COUNT];
  logic [MM_BITS-1:0] act_mm = ACTUATION_RESET;
  logic [MM_BITS-1:0] rel_mm = RELEASE_RESET;
  logic [MM_BITS-1:0] sens_mm = SENSITIVITY_RESET;
  logic               rapid_on = 1'b0;

  in_item_t  send_queue [$];
  out_item_t key_results [$];
  out_item_t want_result;

  int  error_count = 0;
  int  results_seen = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  logic calm = 1'b0;
  int  cycle_count = 0;
  int  queued_items;
  int  stim_lo [KEY_COUNT];
  int  stim_hi [KEY_COUNT];

  task automatic flag_error(input string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  function automatic int clip_sample(input int v);
    if (v < 0) return 0;
    if (v > int'(SAMPLE_MAX)) return int'(SAMPLE_MAX);
    return v;
  endfunction

  function automatic int depth_to_reading(input int mm, input int lo, input int hi);
    return clip_sample(mm * (hi - lo) / MM_FULL + lo);
  endfunction

  // update one key for an accepted transfer and queue the result it gives
  task automatic advance_key_state(input in_item_t it);
    int k, slot, total, mean, lo, hi, act, ext, delta, thr;
    bit now;
    out_item_t res;
    k = int'(it.key);
    if (it.operation == OP_CALIBRATE) begin
      cal_lo[k] = it.bound_low;
      cal_hi[k] = it.bound_high;
    end else begin
      slot = (ring_slot[k] + 1) % RING_LEN;
      ring_slot[k] = slot;
      ring_store[k][slot] = it.reading;
      total = 0;
      for (int i = 0; i < RING_LEN; i++) total += int'(ring_store[k][i]);
      mean = total / RING_LEN;
      lo = int'(cal_lo[k]);
      hi = int'(cal_hi[k]);
      act = depth_to_reading(int'(act_mm), lo, hi);
      ext = int'(extreme[k]);
      if (rapid_on) begin
        delta = depth_to_reading(int'(sens_mm), 0, hi - lo);
        if (key_down[k]) begin
          thr = clip_sample(ext - delta);
          if (mean < thr) begin
            ext = mean;
            now = 0;
          end else begin
            if (mean > ext) ext = mean;
            now = 1;
          end
        end else begin
          thr = clip_sample(ext + delta);
          if (mean > thr && mean > act) begin
            ext = mean;
            now = 1;
          end else begin
            if (mean < ext) ext = mean;
            now = 0;
          end
        end
        extreme[k] = sample_t'(ext);
      end else begin
        thr = depth_to_reading(int'(rel_mm), lo, hi);
        now = key_down[k] ? (mean > thr) : (mean > act);
      end
      key_down[k] = now;
      res.key_out = KEY_BITS'(k);
      res.pressed = now;
      res.average = sample_t'(mean);
      key_results.push_back(res);
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) advance_key_state(in_data);
      if (!in_valid || !in_stall) begin
        if (send_queue.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
          in_data <= send_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (key_results.size() == 0) begin
          flag_error($sformatf("unexpected result key %0d pressed %0d average %0d",
                               out_data.key_out, out_data.pressed, out_data.average));
        end else begin
          want_result = key_results.pop_front();
          if (out_data.key_out !== want_result.key_out)
            flag_error($sformatf("key_out got %0d want %0d",
                                 out_data.key_out, want_result.key_out));
          if (out_data.pressed !== want_result.pressed)
            flag_error($sformatf("key %0d pressed got %0d want %0d", want_result.key_out,
                                 out_data.pressed, want_result.pressed));
          if (out_data.average !== want_result.average)
            flag_error($sformatf("key %0d average got %0d want %0d", want_result.key_out,
                                 out_data.average, want_result.average));
        end
      end
      calm <= results_seen >= 600 && results_seen < 800;
      // hold off once for a long stretch so the block backs up
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (results_seen >= 300 && !hold_done) begin
        hold_done = 1;
        hold_left = 400;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 34);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("analog_key_rapid_trigger_top verification failed");
      $finish;
    end
  end

  task automatic push_sample(input int k, input int r);
    in_item_t it;
    it = '0;
    it.operation = OP_SAMPLE;
    it.key = KEY_BITS'(k);
    it.reading = sample_t'(r);
    it.bound_low = sample_t'($urandom);
    it.bound_high = sample_t'($urandom);
    send_queue.push_back(it);
    queued_items++;
  endtask

  task automatic push_calibration(input int k, input int lo, input int hi);
    in_item_t it;
    it = '0;
    it.operation = OP_CALIBRATE;
    it.key = KEY_BITS'(k);
    it.reading = sample_t'($urandom);
    it.bound_low = sample_t'(lo);
    it.bound_high = sample_t'(hi);
    send_queue.push_back(it);
    stim_lo[k] = lo;
    stim_hi[k] = hi;
    queued_items++;
  endtask

  // press and release one key along a few waypoints of its travel
  task automatic queue_stroke();
    int k, lo, hi, sel, cur, tgt, steps, pct;
    k = $urandom_range(KEY_COUNT - 1);
    if ($urandom_range(99) < 30) begin
      sel = $urandom_range(99);
      lo = $urandom_range(1500);
      hi = $urandom_range(4095, 2500);
      if (sel < 15) push_calibration(k, hi, lo);
      else if (sel < 30) push_calibration(k, $urandom_range(4095), $urandom_range(4095));
      else push_calibration(k, lo, hi);
    end
    lo = stim_lo[k];
    hi = stim_hi[k];
    cur = 0;
    repeat ($urandom_range(6, 3)) begin
      tgt = $urandom_range(100);
      steps = $urandom_range(12, 3);
      for (int s = 1; s <= steps; s++) begin
        pct = cur + (tgt - cur) * s / steps;
        push_sample(k, clip_sample(lo + (hi - lo) * pct / 100 + int'($urandom_range(40)) - 20));
      end
      cur = tgt;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= MM_BITS'(val);
    @(posedge clk);
    case (idx)
      CFG_ACTUATION:   act_mm = MM_BITS'(val);
      CFG_RELEASE:     rel_mm = MM_BITS'(val);
      CFG_RAPID:       rapid_on = val[0];
      CFG_SENSITIVITY: sens_mm = MM_BITS'(val);
      default: ;
    endcase
  endtask

  task automatic set_config(input int a, input int r, input int m, input int s);
    write_reg(CFG_ACTUATION, a);
    write_reg(CFG_RELEASE, r);
    write_reg(CFG_RAPID, m);
    write_reg(CFG_SENSITIVITY, s);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_drained();
    while (send_queue.size() != 0 || in_valid || key_results.size() != 0) @(posedge clk);
    // a trailing calibration transfer gives no result; let it retire
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic int pick_mm();
    return ($urandom_range(9) == 0) ? 63 : $urandom_range(40);
  endfunction

  initial begin
    for (int k = 0; k < KEY_COUNT; k++) begin
      for (int i = 0; i < RING_LEN; i++) ring_store[k][i] = '0;
      ring_slot[k] = 0;
      extreme[k] = '0;
      key_down[k] = 0;
      cal_lo[k] = '0;
      cal_hi[k] = SAMPLE_MAX;
      stim_lo[k] = 0;
      stim_hi[k] = int'(SAMPLE_MAX);
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, reversed and flat bounds, ring fill and wrap
    push_sample(0, 4095);
    push_sample(15, 0);
    push_calibration(2, 4095, 0);
    push_sample(2, 4095);
    push_calibration(3, 0, 0);
    push_sample(3, 1);
    push_calibration(4, 4095, 4095);
    push_sample(4, 4095);
    for (int i = 0; i < 17; i++) push_sample(1, (i < 16) ? 4095 : 0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(20, 15, 1, 3);
        1: set_config(0, 0, 1, 0);
        2: set_config(63, 63, 1, 63);
        3: set_config(40, 0, 0, 40);
        4: set_config(63, 63, 0, 0);
        5: set_config(40, 40, 1, 1);
        default: set_config(pick_mm(), pick_mm(), $urandom_range(1), pick_mm());
      endcase
      queued_items = 0;
      while (queued_items < PHASE_ITEMS) begin
        if ($urandom_range(99) < 15) begin
          if ($urandom_range(99) < 30)
            push_calibration($urandom_range(15), $urandom_range(4095), $urandom_range(4095));
          else
            push_sample($urandom_range(15), $urandom_range(4095));
        end else begin
          queue_stroke();
        end
      end
      wait_drained();
    end

    if (key_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", key_results.size()));
    if (error_count == 0) begin
      $display("analog_key_rapid_trigger_top verification clean");
    end else begin
      $display("analog_key_rapid_trigger_top verification failed");
    end
    $finish;
  end

endmodule
